[design/ycc_ict_pkg.sv]
// ----------------------------------------------------------------------------
// YCbCr to RGB inverse component transform: shared definitions
// Widths, register indexes and fixed-point coefficients of the transform.
// ----------------------------------------------------------------------------
package ycc_ict_pkg;

    localparam int COEF_FRAC_BITS = 14;
    localparam int SAMPLE_W       = 16;
    localparam int SMP_W          = SAMPLE_W + 1;
    localparam int COEF_W         = COEF_FRAC_BITS + 1;
    localparam int SUM_W          = SAMPLE_W + 4;
    localparam int ACC_W          = COEF_FRAC_BITS + SUM_W;
    localparam int PROD_W         = SMP_W + COEF_W + 1;
    localparam int DEPTH_W        = 5;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(8);
    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = DEPTH_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = DEPTH_W'(SAMPLE_W);

    localparam longint unsigned FIX_ONE = 64'd1 << COEF_FRAC_BITS;

    localparam logic [COEF_W-1:0] COEF_CR_R =
        COEF_W'((64'd1402 * FIX_ONE * 64'd2 + 64'd1000) / 64'd2000);
    localparam logic [COEF_W-1:0] COEF_CB_B =
        COEF_W'((64'd1772 * FIX_ONE * 64'd2 + 64'd1000) / 64'd2000);
    localparam logic [COEF_W-1:0] COEF_CR_G =
        COEF_W'((64'd419198 * FIX_ONE * 64'd2 + 64'd587000) / 64'd1174000);
    localparam logic [COEF_W-1:0] COEF_CB_G =
        COEF_W'((64'd202008 * FIX_ONE * 64'd2 + 64'd587000) / 64'd1174000);

    typedef enum logic [1:0] {
        REG_SAMPLE_DEPTH = 2'd0,
        REG_SIGNED       = 2'd1,
        REG_REVERSIBLE   = 2'd2
    } reg_idx_t;

    typedef logic [SAMPLE_W-1:0]      sample_t;
    typedef logic signed [SMP_W-1:0]  smp_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

[design/ycc_ict_if.sv]
// ----------------------------------------------------------------------------
// YCbCr to RGB inverse component transform: stream interfaces
// Valid/ready channels for the YCbCr pixel input and the RGB result.
// ----------------------------------------------------------------------------
interface ycc_ict_pix_if;
    logic                 valid;
    logic                 ready;
    ycc_ict_pkg::sample_t luma;
    ycc_ict_pkg::sample_t chroma_blue;
    ycc_ict_pkg::sample_t chroma_red;

    modport source (output valid, output luma, output chroma_blue, output chroma_red,
                    input ready);
    modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                    output ready);
endinterface

interface ycc_ict_rgb_if;
    logic                 valid;
    logic                 ready;
    ycc_ict_pkg::sample_t red;
    ycc_ict_pkg::sample_t green;
    ycc_ict_pkg::sample_t blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);
endinterface

[design/ycc_to_rgb_inverse_component_transform_core.sv]
// ----------------------------------------------------------------------------
// YCbCr to RGB inverse component transform core
// Converts one YCbCr pixel per beat to RGB with the reversible integer RCT or
// the irreversible fixed-point ICT, then restores the offset and saturates.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  pix      in         valid/ready              luma, chroma_blue, chroma_red
//  rgb      out        valid/ready              red, green, blue
//  apb      in         psel/penable, pready=1   sample_depth, signed_samples,
//                                               reversible_mode
//
//  One pixel is accepted every clock while the output is not stalled; its result
//  passes the input register and then the result register before it is shown.
//  The input register and the result register each hold one beat, so input is
//  taken while a finished result waits; a stalled output backs up after two beats.
//  The critical path is the constant multiply and accumulate of the ICT green term.
//  Reset clears both valid flags and loads the register defaults (depth 8).
// ----------------------------------------------------------------------------
module ycc_to_rgb_inverse_component_transform_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    ycc_ict_pix_if.sink                       pix,
    ycc_ict_rgb_if.source                     rgb,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ycc_ict_pkg::ADDR_W-1:0]    paddr,
    input  logic [ycc_ict_pkg::DATA_W-1:0]    pwdata,
    output logic [ycc_ict_pkg::DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [ycc_ict_pkg::DEPTH_W-1:0] depth_reg;
    logic                            signed_reg;
    logic                            rev_reg;
    logic                            cfg_write;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    ycc_ict_pkg::sample_t s1_luma_reg;
    ycc_ict_pkg::sample_t s1_cb_reg;
    ycc_ict_pkg::sample_t s1_cr_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    ycc_ict_pkg::sample_t out_red_reg;
    ycc_ict_pkg::sample_t out_green_reg;
    ycc_ict_pkg::sample_t out_blue_reg;

    logic                 out_free;
    logic                 s1_adv;
    logic                 in_take;

    logic [ycc_ict_pkg::DEPTH_W-1:0] depth_eff;
    logic [ycc_ict_pkg::SAMPLE_W-1:0] mask;
    logic [ycc_ict_pkg::SMP_W-1:0]   full_range;
    logic [ycc_ict_pkg::SMP_W-1:0]   half_range;
    logic [ycc_ict_pkg::SMP_W-1:0]   offset;
    logic [ycc_ict_pkg::SMP_W-1:0]   max_val;

    ycc_ict_pkg::smp_t  y_s;
    ycc_ict_pkg::smp_t  cb_s;
    ycc_ict_pkg::smp_t  cr_s;
    ycc_ict_pkg::sum_t  ofs_sum;
    ycc_ict_pkg::sum_t  cbcr_sum;
    ycc_ict_pkg::sum_t  rct_g;
    ycc_ict_pkg::sum_t  rct_r_out;
    ycc_ict_pkg::sum_t  rct_g_out;
    ycc_ict_pkg::sum_t  rct_b_out;
    ycc_ict_pkg::prod_t prod_cr_r;
    ycc_ict_pkg::prod_t prod_cb_b;
    ycc_ict_pkg::prod_t prod_cr_g;
    ycc_ict_pkg::prod_t prod_cb_g;
    ycc_ict_pkg::acc_t  y_fix;
    ycc_ict_pkg::acc_t  ofs_fix;
    ycc_ict_pkg::acc_t  ict_r;
    ycc_ict_pkg::acc_t  ict_g;
    ycc_ict_pkg::acc_t  ict_b;
    ycc_ict_pkg::sample_t red_next;
    ycc_ict_pkg::sample_t green_next;
    ycc_ict_pkg::sample_t blue_next;

    function automatic ycc_ict_pkg::smp_t to_sample
    (
        input ycc_ict_pkg::sample_t           raw,
        input logic [ycc_ict_pkg::SAMPLE_W-1:0] m,
        input logic [ycc_ict_pkg::SMP_W-1:0]  half,
        input logic [ycc_ict_pkg::SMP_W-1:0]  full,
        input logic                           is_signed
    );
        logic [ycc_ict_pkg::SMP_W-1:0] v;
        logic [ycc_ict_pkg::SMP_W-1:0] res;
        v = {1'b0, raw & m};
        if (is_signed)
        begin
            res = ((v & half) != '0) ? (v - full) : v;
        end
        else
        begin
            res = v - half;
        end
        return $signed(res);
    endfunction

    function automatic ycc_ict_pkg::sample_t saturate
    (
        input ycc_ict_pkg::sum_t              v,
        input logic [ycc_ict_pkg::SMP_W-1:0]  maxv
    );
        ycc_ict_pkg::sample_t res;
        if (v[ycc_ict_pkg::SUM_W-1])
        begin
            res = '0;
        end
        else if ($unsigned(v) > ycc_ict_pkg::SUM_W'(maxv))
        begin
            res = maxv[ycc_ict_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            res = v[ycc_ict_pkg::SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= ycc_ict_pkg::DEPTH_RESET;
            signed_reg <= 1'b0;
            rev_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                ycc_ict_pkg::REG_SAMPLE_DEPTH: depth_reg  <= pwdata[ycc_ict_pkg::DEPTH_W-1:0];
                ycc_ict_pkg::REG_SIGNED:       signed_reg <= pwdata[0];
                ycc_ict_pkg::REG_REVERSIBLE:   rev_reg    <= pwdata[0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ycc_ict_pkg::REG_SAMPLE_DEPTH: prdata = ycc_ict_pkg::DATA_W'(depth_reg);
            ycc_ict_pkg::REG_SIGNED:       prdata = ycc_ict_pkg::DATA_W'(signed_reg);
            ycc_ict_pkg::REG_REVERSIBLE:   prdata = ycc_ict_pkg::DATA_W'(rev_reg);
            default:                       prdata = '0;
        endcase
    end

    // Handshake: input register, then result register.
    assign out_free  = !out_valid_reg || rgb.ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign pix.ready = !s1_valid_reg || out_free;
    assign in_take   = pix.valid && pix.ready;

    always_comb
    begin
        s1_valid_next  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_luma_reg <= pix.luma;
            s1_cb_reg   <= pix.chroma_blue;
            s1_cr_reg   <= pix.chroma_red;
        end
        if (s1_adv)
        begin
            out_red_reg   <= red_next;
            out_green_reg <= green_next;
            out_blue_reg  <= blue_next;
        end
    end

    // Depth-derived ranges; depths outside one to sixteen are clamped.
    always_comb
    begin
        priority if (depth_reg < ycc_ict_pkg::DEPTH_MIN)
        begin
            depth_eff = ycc_ict_pkg::DEPTH_MIN;
        end
        else if (depth_reg > ycc_ict_pkg::DEPTH_MAX)
        begin
            depth_eff = ycc_ict_pkg::DEPTH_MAX;
        end
        else
        begin
            depth_eff = depth_reg;
        end
        full_range = ycc_ict_pkg::SMP_W'(1) << depth_eff;
        half_range = ycc_ict_pkg::SMP_W'(1) << (depth_eff - ycc_ict_pkg::DEPTH_MIN);
        mask       = ycc_ict_pkg::SAMPLE_W'(full_range - ycc_ict_pkg::SMP_W'(1));
        offset     = signed_reg ? '0 : half_range;
        max_val    = signed_reg ? (half_range - ycc_ict_pkg::SMP_W'(1))
                                : (full_range - ycc_ict_pkg::SMP_W'(1));
    end

    // Transform datapath.
    always_comb
    begin
        y_s  = to_sample(s1_luma_reg, mask, half_range, full_range, signed_reg);
        cb_s = to_sample(s1_cb_reg,   mask, half_range, full_range, signed_reg);
        cr_s = to_sample(s1_cr_reg,   mask, half_range, full_range, signed_reg);

        ofs_sum   = $signed(ycc_ict_pkg::SUM_W'(offset));
        cbcr_sum  = ycc_ict_pkg::SUM_W'(cb_s) + ycc_ict_pkg::SUM_W'(cr_s);
        rct_g     = ycc_ict_pkg::SUM_W'(y_s) - (cbcr_sum >>> 2);
        rct_r_out = rct_g + ycc_ict_pkg::SUM_W'(cr_s) + ofs_sum;
        rct_g_out = rct_g + ofs_sum;
        rct_b_out = rct_g + ycc_ict_pkg::SUM_W'(cb_s) + ofs_sum;

        prod_cr_r = cr_s * $signed({1'b0, ycc_ict_pkg::COEF_CR_R});
        prod_cb_b = cb_s * $signed({1'b0, ycc_ict_pkg::COEF_CB_B});
        prod_cr_g = cr_s * $signed({1'b0, ycc_ict_pkg::COEF_CR_G});
        prod_cb_g = cb_s * $signed({1'b0, ycc_ict_pkg::COEF_CB_G});

        y_fix   = ycc_ict_pkg::ACC_W'(y_s) <<< ycc_ict_pkg::COEF_FRAC_BITS;
        ofs_fix = ($signed(ycc_ict_pkg::ACC_W'(offset)) <<< ycc_ict_pkg::COEF_FRAC_BITS)
                + (ycc_ict_pkg::acc_t'(1) <<< (ycc_ict_pkg::COEF_FRAC_BITS - 1));

        ict_r = y_fix + ycc_ict_pkg::ACC_W'(prod_cr_r) + ofs_fix;
        ict_g = y_fix - ycc_ict_pkg::ACC_W'(prod_cr_g) - ycc_ict_pkg::ACC_W'(prod_cb_g)
              + ofs_fix;
        ict_b = y_fix + ycc_ict_pkg::ACC_W'(prod_cb_b) + ofs_fix;

        if (rev_reg)
        begin
            red_next   = saturate(rct_r_out, max_val);
            green_next = saturate(rct_g_out, max_val);
            blue_next  = saturate(rct_b_out, max_val);
        end
        else
        begin
            red_next   = saturate(ict_r[ycc_ict_pkg::ACC_W-1:ycc_ict_pkg::COEF_FRAC_BITS],
                                  max_val);
            green_next = saturate(ict_g[ycc_ict_pkg::ACC_W-1:ycc_ict_pkg::COEF_FRAC_BITS],
                                  max_val);
            blue_next  = saturate(ict_b[ycc_ict_pkg::ACC_W-1:ycc_ict_pkg::COEF_FRAC_BITS],
                                  max_val);
        end
    end

    assign rgb.valid = out_valid_reg;
    assign rgb.red   = out_red_reg;
    assign rgb.green = out_green_reg;
    assign rgb.blue  = out_blue_reg;

endmodule

[design/ycc_ict_checker.sv]
// ----------------------------------------------------------------------------
// YCbCr to RGB inverse component transform: port checker
// Watches the stream ports of the core for latency and handshake behavior.
// ----------------------------------------------------------------------------
module ycc_ict_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input ycc_ict_pkg::sample_t red,
    input ycc_ict_pkg::sample_t green,
    input ycc_ict_pkg::sample_t blue
);

    // Every accepted pixel shows a result once it has passed the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 out_valid)
        else $error("accepted pixel produced no result after two cycles");

    // A new result appears only after an input beat has passed the input and result registers.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a matching input beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(red) && $stable(green) && $stable(blue)))
        else $error("result payload changed while stalled");

endmodule

bind ycc_to_rgb_inverse_component_transform_core ycc_ict_checker u_ycc_ict_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .red       (rgb.red),
    .green     (rgb.green),
    .blue      (rgb.blue)
);
